// File: hdl/ohlc_pkg.sv
// ----------------------------------------------------------------------------
// OHLC bar aggregator package
// Field widths, constants and the word types shared by the channels and RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package ohlc_pkg;

    localparam int TIME_W   = 40;
    localparam int PRICE_W  = 32;
    localparam int DAY_W    = 16;
    localparam int PERIOD_W = 11;
    // Period in seconds: at most 2047 * 60, which fits in 17 bits.
    localparam int PER_SEC_W = 17;
    // Product of a trading day and the seconds of one day.
    localparam int DAY_SEC_W = DAY_W + PER_SEC_W;

    localparam logic [PERIOD_W-1:0]  DAILY_MINUTES      = PERIOD_W'(1440);
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET       = PERIOD_W'(1);
    localparam logic [PER_SEC_W-1:0] SECONDS_PER_MINUTE = PER_SEC_W'(60);
    localparam logic [PER_SEC_W-1:0] SECONDS_PER_DAY    = PER_SEC_W'(86400);

    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] price;
        logic [PRICE_W-1:0] session_open;
        logic [PRICE_W-1:0] day_volume;
        logic [PRICE_W-1:0] open_interest;
        logic [PRICE_W-1:0] lower_limit;
        logic [PRICE_W-1:0] upper_limit;
        logic [DAY_W-1:0]   trading_day;
    } t_tick;

    typedef struct packed {
        logic               accepted;
        logic               new_bar;
        logic [TIME_W-1:0]  bar_start;
        logic [PRICE_W-1:0] bar_open;
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_close;
        logic [PRICE_W-1:0] bar_volume;
        logic [PRICE_W-1:0] bar_interest;
        logic [PRICE_W-1:0] bar_lower_limit;
        logic [PRICE_W-1:0] bar_upper_limit;
    } t_bar;

endpackage

`default_nettype wire

// File: hdl/ohlc_tick_if.sv
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel that carries one market tick word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohlc_tick_if;
    import ohlc_pkg::*;

    logic  valid;
    logic  ready;
    t_tick payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ohlc_bar_if.sv
// ----------------------------------------------------------------------------
// Bar channel
// Valid/ready channel that carries one bar result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohlc_bar_if;
    import ohlc_pkg::*;

    logic valid;
    logic ready;
    t_bar payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ohlc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the bar period register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohlc_cfg_if;
    import ohlc_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/ohlc_bar_aggregator.sv
// ----------------------------------------------------------------------------
// OHLC bar aggregator
// Merges market ticks into the current open-high-low-close bar and returns
// the bar as it stands after every tick.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word                           Accepted when
//  i_tick    in         t_tick market tick             valid && ready
//  o_bar     out        t_bar bar after the tick       valid && ready
//  i_cfg     in         period_minutes (11 bits)       valid && ready
//
// A tick goes through capture, check and commit between acceptance and its
// result. A tick that opens an intraday bar also passes through the restoring
// remainder unit, which brings in one time bit at a time and floors the tick
// time to a multiple of the period before the commit.
// The commit waits while the previous result word is still held in the
// output register; a new tick is taken as soon as the commit is done.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_bar_aggregator (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ohlc_tick_if.sink    i_tick,
    ohlc_bar_if.source   o_bar,
    ohlc_cfg_if.sink     i_cfg
);
    import ohlc_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state               r_state;
    logic [PERIOD_W-1:0]  r_period;
    t_tick                r_tick;

    // Aggregation state.
    logic [PRICE_W-1:0]   r_last_volume;
    logic [PRICE_W-1:0]   r_base_volume;
    logic                 r_bar_valid;
    logic [TIME_W-1:0]    r_cur_start;
    logic [DAY_W-1:0]     r_cur_day;
    logic [PRICE_W-1:0]   r_cur_open;
    logic [PRICE_W-1:0]   r_cur_high;
    logic [PRICE_W-1:0]   r_cur_low;
    logic [PRICE_W-1:0]   r_cur_close;
    logic [PRICE_W-1:0]   r_cur_volume;
    logic [PRICE_W-1:0]   r_cur_interest;
    logic [PRICE_W-1:0]   r_cur_lower;
    logic [PRICE_W-1:0]   r_cur_upper;

    // Decision and remainder unit.
    logic                 r_acc;
    logic                 r_fresh;
    logic                 r_daily;
    logic [PER_SEC_W-1:0] r_per;
    logic [PER_SEC_W-1:0] r_rem;
    logic [TIME_W-1:0]    r_shift;
    logic [CNT_W-1:0]     r_cnt;

    // Output register.
    logic                 r_out_valid;
    t_bar                 r_out;

    logic                 n_acc;
    logic                 n_fresh;
    logic                 n_daily;
    logic [PER_SEC_W-1:0] n_per;
    logic [PER_SEC_W-1:0] n_rem;
    logic [TIME_W:0]      diff;
    logic [PER_SEC_W:0]   rem_sh;
    logic [DAY_SEC_W-1:0] day_sec;
    logic [TIME_W-1:0]    n_start;
    logic                 out_free;
    t_bar                 n_out;

    assign i_tick.ready  = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_bar.valid   = r_out_valid;
    assign o_bar.payload = r_out;

    assign out_free = !r_out_valid || o_bar.ready;

    // Check step: acceptance on rising day volume, and whether the tick opens
    // a bar. A zero period counts as one minute.
    always_comb begin
        n_daily = (r_period == DAILY_MINUTES);
        n_acc   = (r_tick.day_volume > r_last_volume);
        n_per   = PER_SEC_W'((r_period == '0) ? PERIOD_W'(1) : r_period)
                  * SECONDS_PER_MINUTE;
        diff    = {1'b0, r_tick.tick_time} - {1'b0, r_cur_start};
        if (!r_bar_valid) begin
            n_fresh = 1'b1;
        end else if (n_daily) begin
            n_fresh = (r_tick.trading_day != r_cur_day);
        end else begin
            n_fresh = !diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_W'(n_per));
        end
    end

    // One step of the restoring remainder: bring in the next time bit and
    // subtract the period when it fits.
    always_comb begin
        rem_sh = {r_rem, r_shift[TIME_W-1]};
        if (rem_sh >= {1'b0, r_per}) begin
            n_rem = PER_SEC_W'(rem_sh - {1'b0, r_per});
        end else begin
            n_rem = PER_SEC_W'(rem_sh);
        end
    end

    // Commit step: the new bar start, and the result word after the update.
    always_comb begin
        day_sec = DAY_SEC_W'(r_tick.trading_day) * DAY_SEC_W'(SECONDS_PER_DAY);
        if (r_daily) begin
            n_start = TIME_W'(day_sec);
        end else begin
            n_start = r_tick.tick_time - TIME_W'(r_rem);
        end

        n_out.accepted        = r_acc;
        n_out.new_bar         = r_acc && r_fresh;
        n_out.bar_start       = r_cur_start;
        n_out.bar_open        = r_cur_open;
        n_out.bar_high        = r_cur_high;
        n_out.bar_low         = r_cur_low;
        n_out.bar_close       = r_cur_close;
        n_out.bar_volume      = r_cur_volume;
        n_out.bar_interest    = r_cur_interest;
        n_out.bar_lower_limit = r_cur_lower;
        n_out.bar_upper_limit = r_cur_upper;
        if (r_acc) begin
            if (r_fresh) begin
                n_out.bar_start       = n_start;
                n_out.bar_open        = (r_last_volume == '0) ? r_tick.session_open
                                                              : r_tick.price;
                n_out.bar_high        = r_tick.price;
                n_out.bar_low         = r_tick.price;
                n_out.bar_lower_limit = r_tick.lower_limit;
                n_out.bar_upper_limit = r_tick.upper_limit;
                n_out.bar_volume      = r_tick.day_volume - r_last_volume;
            end else begin
                if (r_tick.price > r_cur_high) begin
                    n_out.bar_high = r_tick.price;
                end
                if (r_tick.price < r_cur_low) begin
                    n_out.bar_low = r_tick.price;
                end
                n_out.bar_volume = r_tick.day_volume - r_base_volume;
            end
            n_out.bar_close    = r_tick.price;
            n_out.bar_interest = r_tick.open_interest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_period       <= PERIOD_RESET;
            r_out_valid    <= 1'b0;
            r_last_volume  <= '0;
            r_base_volume  <= '0;
            r_bar_valid    <= 1'b0;
            r_cur_start    <= '0;
            r_cur_day      <= '0;
            r_cur_open     <= '0;
            r_cur_high     <= '0;
            r_cur_low      <= '0;
            r_cur_close    <= '0;
            r_cur_volume   <= '0;
            r_cur_interest <= '0;
            r_cur_lower    <= '0;
            r_cur_upper    <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_period <= i_cfg.data;
            end
            // A word taken in the cycle of a commit is replaced, not cleared.
            if (r_out_valid && o_bar.ready && !(r_state == S_COMMIT && out_free)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_tick.valid) begin
                        r_tick  <= i_tick.payload;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_acc   <= n_acc;
                    r_fresh <= n_fresh;
                    r_daily <= n_daily;
                    r_per   <= n_per;
                    r_rem   <= '0;
                    r_shift <= r_tick.tick_time;
                    r_cnt   <= '0;
                    if (n_acc && n_fresh && !n_daily) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_COMMIT;
                    end
                end
                S_DIV: begin
                    r_rem   <= n_rem;
                    r_shift <= {r_shift[TIME_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (out_free) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_acc) begin
                            if (r_fresh) begin
                                r_base_volume <= r_last_volume;
                                r_cur_day     <= r_tick.trading_day;
                                r_bar_valid   <= 1'b1;
                            end
                            r_last_volume  <= r_tick.day_volume;
                            r_cur_start    <= n_out.bar_start;
                            r_cur_open     <= n_out.bar_open;
                            r_cur_high     <= n_out.bar_high;
                            r_cur_low      <= n_out.bar_low;
                            r_cur_close    <= n_out.bar_close;
                            r_cur_volume   <= n_out.bar_volume;
                            r_cur_interest <= n_out.bar_interest;
                            r_cur_lower    <= n_out.bar_lower_limit;
                            r_cur_upper    <= n_out.bar_upper_limit;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A tick is taken only from idle, so the next cycle is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.valid && i_tick.ready) |=> !i_tick.ready)
        else $error("tick channel ready right after a tick was taken");

    // The low of a bar never rises above its high.
    a_low_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bar.valid |-> (o_bar.payload.bar_low <= o_bar.payload.bar_high))
        else $error("bar low above bar high");

    // A new bar is reported only for an accepted tick.
    a_new_bar_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bar.valid && o_bar.payload.new_bar) |-> o_bar.payload.accepted)
        else $error("new bar on a rejected tick");

    // The remainder unit never divides by a zero period.
    a_div_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_per != '0))
        else $error("zero period in the remainder unit");

    // A result word appears only out of the commit step.
    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_COMMIT))
        else $error("result word outside the commit step");
`endif

endmodule

`default_nettype wire
